// ===== hw/rtl/hslpa_pkg.sv =====
// Shared constants and types of the HSL saturation and lightness adjust pipeline.
package hslpa_pkg;

    localparam int FRAC_BITS = 24;
    localparam int GAIN_BITS = 12;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 8;
    localparam int Q_W       = FRAC_BITS + 1;   // fractions in [0, ONE]
    localparam int LP_W      = 28;              // scaled lightness / saturation
    localparam int H6_W      = 27;              // hue * 6, up to 6 * ONE
    localparam int V_W       = 38;              // signed rebuild intermediates

    localparam longint unsigned ONE = 64'd1 << FRAC_BITS;

    // Register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_LIGHTNESS_GAIN  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION_GAIN = 8'd1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    // Lightness is ceil(sum * ONE / 510): sum * LUM_Q0 + (sum * LUM_R0 + 509) / 510
    localparam longint unsigned LUM_DIV  = 64'd510;
    localparam longint unsigned LUM_Q0   = ONE / LUM_DIV;
    localparam longint unsigned LUM_R0   = ONE % LUM_DIV;
    localparam int              LUM_SH   = 26;
    localparam longint unsigned LUM_M    = ((64'd1 << LUM_SH) + LUM_DIV - 1) / LUM_DIV;

    typedef struct packed {
        logic [7:0]      alpha;
        logic [LP_W-1:0] lp;
        logic [LP_W-1:0] sp;
        logic [H6_W-1:0] h6;
    } hslpa_hsl_t;

endpackage

// ===== hw/rtl/hslpa_recip_div.sv =====
// Four-stage divider of a fraction n * ONE / d, rounded half up, for 8-bit n <= d.
module hslpa_recip_div (
    input  logic                    aclk,
    input  logic                    en,
    input  logic [7:0]              num,
    input  logic [7:0]              den,
    output logic [hslpa_pkg::Q_W-1:0] quot
);

    localparam int QW = hslpa_pkg::Q_W;

    logic [QW-1:0] q0_tbl [256];
    logic [7:0]    r0_tbl [256];
    logic [QW-1:0] rc_tbl [256];

    // ONE = q0 * d + r0, and rc = ceil(ONE / d) for the small remainder divide
    for (genvar i = 0; i < 256; i++) begin : g_tbl
        localparam longint unsigned DV = (i == 0) ? 64'd1 : 64'(i);
        localparam longint unsigned Q0 = hslpa_pkg::ONE / DV;
        localparam longint unsigned R0 = hslpa_pkg::ONE % DV;
        localparam longint unsigned RC = (hslpa_pkg::ONE + DV - 1) / DV;
        assign q0_tbl[i] = Q0[QW-1:0];
        assign r0_tbl[i] = R0[7:0];
        assign rc_tbl[i] = RC[QW-1:0];
    end

    logic [7:0]    n_a_reg;
    logic [6:0]    h_a_reg;
    logic [QW-1:0] q0_a_reg;
    logic [7:0]    r0_a_reg;
    logic [QW-1:0] rc_a_reg;

    logic [QW-1:0] p1_b_reg;
    logic [15:0]   t_b_reg;
    logic [QW-1:0] rc_b_reg;

    logic [QW-1:0] p1_c_reg;
    logic [16:0]   p2_c_reg;

    logic [QW-1:0] quot_reg;

    logic [32:0] p1_full;
    logic [15:0] t_next;
    logic [40:0] p2_full;

    assign p1_full = 33'(n_a_reg) * 33'(q0_a_reg);
    assign t_next  = 16'(16'(n_a_reg) * 16'(r0_a_reg)) + 16'(h_a_reg);
    assign p2_full = 41'(t_b_reg) * 41'(rc_b_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            n_a_reg  <= num;
            h_a_reg  <= den[7:1];
            q0_a_reg <= q0_tbl[den];
            r0_a_reg <= r0_tbl[den];
            rc_a_reg <= rc_tbl[den];

            p1_b_reg <= p1_full[QW-1:0];
            t_b_reg  <= t_next;
            rc_b_reg <= rc_a_reg;

            p1_c_reg <= p1_b_reg;
            p2_c_reg <= p2_full[40:24];

            quot_reg <= p1_c_reg + QW'(p2_c_reg);
        end
    end

    assign quot = quot_reg;

endmodule

// ===== hw/rtl/hslpa_rgb_rebuild.sv =====
// Five-stage rebuild of RGB bytes from scaled lightness, saturation and hue.
module hslpa_rgb_rebuild (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  hslpa_pkg::hslpa_hsl_t in_hsl,
    output logic                  out_valid,
    output logic [31:0]           out_pixel   // alpha, red, green, blue from bit 0 up
);

    localparam int LPW = hslpa_pkg::LP_W;
    localparam int VW  = hslpa_pkg::V_W;
    localparam int QW  = hslpa_pkg::Q_W;
    localparam logic [LPW-1:0] HALF = LPW'(hslpa_pkg::ONE >> 1);
    localparam logic signed [63:0] ROUND_TZ = 64'(hslpa_pkg::ONE - 1);

    function automatic logic [7:0] to_byte(input logic signed [VW-1:0] c);
        logic [47:0] prod;
        logic [23:0] t;
        prod = 48'(c) * 48'd255 + 48'd64;
        t    = prod[47:24];
        if (c <= 0)
            return 8'd0;
        else if (t > 24'd255)
            return 8'd255;
        else
            return t[7:0];
    endfunction

    logic [4:0] vld_reg;

    // stage 7
    logic [7:0]     alpha7_reg, alpha8_reg, alpha9_reg, alpha10_reg;
    logic [LPW-1:0] lp7_reg, sp7_reg;
    logic [32:0]    ma7_reg;
    logic [31:0]    mb7_reg;
    logic           le7_reg;
    logic [2:0]     sext7_reg, sext8_reg, sext9_reg, sext10_reg;
    logic [QW-1:0]  f7_reg, f8_reg;
    // stage 8
    logic signed [VW-1:0] v8_reg, y8_reg, dvy8_reg;
    // stage 9
    logic signed [VW-1:0] v9_reg, y9_reg;
    logic signed [63:0]   wp9_reg;
    // stage 10
    logic signed [VW-1:0] v10_reg, x10_reg, y10_reg, z10_reg;
    // stage 11
    logic [31:0] pix_reg;

    logic [56:0] ma_full;
    logic [55:0] mb_full;
    logic [2:0]  sext_next;
    logic [hslpa_pkg::H6_W-1:0] f_wide;
    logic signed [VW-1:0] v_next, y_next, w_next;
    logic signed [63:0]   wr_next;
    logic signed [VW-1:0] cr, cg, cb;

    assign ma_full   = 57'(in_hsl.lp) * (57'(hslpa_pkg::ONE) + 57'(in_hsl.sp));
    assign mb_full   = 56'(in_hsl.lp) * 56'(in_hsl.sp);
    assign sext_next = (in_hsl.h6[26:24] > 3'd5) ? 3'd5 : in_hsl.h6[26:24];
    assign f_wide    = in_hsl.h6 - {sext_next, 24'd0};

    assign v_next = le7_reg ? $signed(VW'(ma7_reg))
                            : $signed(VW'(lp7_reg)) + $signed(VW'(sp7_reg))
                              - $signed(VW'(mb7_reg));
    assign y_next = $signed(VW'({lp7_reg, 1'b0})) - v_next;

    // truncate toward zero
    assign wr_next = (wp9_reg < 0) ? wp9_reg + ROUND_TZ : wp9_reg;
    assign w_next  = VW'(wr_next >>> hslpa_pkg::FRAC_BITS);

    always_comb begin
        case (sext10_reg)
            3'd0: begin cr = v10_reg; cg = x10_reg; cb = y10_reg; end
            3'd1: begin cr = z10_reg; cg = v10_reg; cb = y10_reg; end
            3'd2: begin cr = y10_reg; cg = v10_reg; cb = x10_reg; end
            3'd3: begin cr = y10_reg; cg = z10_reg; cb = v10_reg; end
            3'd4: begin cr = x10_reg; cg = y10_reg; cb = v10_reg; end
            default: begin cr = v10_reg; cg = y10_reg; cb = z10_reg; end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            alpha7_reg <= in_hsl.alpha;
            lp7_reg    <= in_hsl.lp;
            sp7_reg    <= in_hsl.sp;
            ma7_reg    <= ma_full[56:24];
            mb7_reg    <= mb_full[55:24];
            le7_reg    <= (in_hsl.lp <= HALF);
            sext7_reg  <= sext_next;
            f7_reg     <= f_wide[QW-1:0];

            alpha8_reg <= alpha7_reg;
            sext8_reg  <= sext7_reg;
            f8_reg     <= f7_reg;
            v8_reg     <= v_next;
            y8_reg     <= y_next;
            dvy8_reg   <= v_next - y_next;

            alpha9_reg <= alpha8_reg;
            sext9_reg  <= sext8_reg;
            v9_reg     <= v8_reg;
            y9_reg     <= y8_reg;
            wp9_reg    <= 64'(dvy8_reg) * $signed(64'(f8_reg));

            alpha10_reg <= alpha9_reg;
            sext10_reg  <= sext9_reg;
            v10_reg     <= v9_reg;
            y10_reg     <= y9_reg;
            x10_reg     <= y9_reg + w_next;
            z10_reg     <= v9_reg - w_next;

            // nonpositive V forces black
            if (v10_reg <= 0)
                pix_reg <= {24'd0, alpha10_reg};
            else
                pix_reg <= {to_byte(cb), to_byte(cg), to_byte(cr), alpha10_reg};
        end
    end

    assign out_valid  = vld_reg[4];
    assign out_pixel  = pix_reg;

endmodule

// ===== hw/rtl/hsl_lum_sat_pixel_adjust_unit.sv =====
// HSL saturation and lightness adjust of an ARGB8888 pixel stream, top level.
// Throughput: one pixel per cycle; the whole pipe advances when the output
// register is empty or taken, and holds as one while a waiting output beat
// sees m_tready low.
// Reset (aresetn low, synchronous) empties the pipe and sets both gains to
// 1.0 (4096); payload registers are not reset.
module hsl_lum_sat_pixel_adjust_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input pixels
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // alpha_in[7:0], red_in, green_in, blue_in[31:24]
    // adjusted pixels
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // alpha_out[7:0], red_out, green_out, blue_out[31:24]
    // register writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [hslpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hslpa_pkg::GAIN_W-1:0]    cfg_data
);

    localparam int QW  = hslpa_pkg::Q_W;
    localparam int LPW = hslpa_pkg::LP_W;
    localparam int H6W = hslpa_pkg::H6_W;
    localparam logic [H6W-1:0] ONE_H = H6W'(hslpa_pkg::ONE);

    // hue formula selected by which channels are largest and smallest
    localparam logic [2:0] HUE_R_MAX_G_MIN = 3'd0;
    localparam logic [2:0] HUE_R_MAX       = 3'd1;
    localparam logic [2:0] HUE_G_MAX_B_MIN = 3'd2;
    localparam logic [2:0] HUE_G_MAX       = 3'd3;
    localparam logic [2:0] HUE_B_MAX_R_MIN = 3'd4;
    localparam logic [2:0] HUE_B_MAX       = 3'd5;

    logic en;
    logic [5:0] vld_reg;   // valid of stages 1..6

    logic [hslpa_pkg::GAIN_W-1:0] lgain_reg, sgain_reg;

    // advance whenever the final output register can move on
    assign en        = m_tready || !m_tvalid;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg   <= '0;
            lgain_reg <= hslpa_pkg::GAIN_RESET;
            sgain_reg <= hslpa_pkg::GAIN_RESET;
        end else begin
            if (en)
                vld_reg <= {vld_reg[4:0], s_tvalid};
            if (cfg_valid) begin
                case (cfg_index)
                    hslpa_pkg::REG_LIGHTNESS_GAIN:  lgain_reg <= cfg_data;
                    hslpa_pkg::REG_SATURATION_GAIN: sgain_reg <= cfg_data;
                    default: ;   // drop writes to unknown registers
                endcase
            end
        end
    end

    // ---------------- stage 1: min, max, sum, spread, hue case ----------------
    logic [7:0] r_in, g_in, b_in;
    logic [7:0] mx_next, mn_next, mxrg, mnrg;
    logic [8:0] sum_next;
    logic [2:0] hsel_next;

    assign r_in = s_tdata[15:8];
    assign g_in = s_tdata[23:16];
    assign b_in = s_tdata[31:24];
    assign mxrg = (r_in > g_in) ? r_in : g_in;
    assign mnrg = (r_in < g_in) ? r_in : g_in;
    assign mx_next  = (b_in > mxrg) ? b_in : mxrg;
    assign mn_next  = (b_in < mnrg) ? b_in : mnrg;
    assign sum_next = 9'(mx_next) + 9'(mn_next);

    always_comb begin
        if (mx_next == r_in)
            hsel_next = (g_in == mn_next) ? HUE_R_MAX_G_MIN : HUE_R_MAX;
        else if (mx_next == g_in)
            hsel_next = (b_in == mn_next) ? HUE_G_MAX_B_MIN : HUE_G_MAX;
        else
            hsel_next = (r_in == mn_next) ? HUE_B_MAX_R_MIN : HUE_B_MAX;
    end

    logic [7:0] alpha1_reg, r1_reg, g1_reg, b1_reg, mx1_reg, d1_reg, den1_reg;
    logic [8:0] sum1_reg;
    logic       chroma1_reg;
    logic [2:0] hsel1_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            alpha1_reg  <= s_tdata[7:0];
            r1_reg      <= r_in;
            g1_reg      <= g_in;
            b1_reg      <= b_in;
            mx1_reg     <= mx_next;
            d1_reg      <= mx_next - mn_next;
            sum1_reg    <= sum_next;
            den1_reg    <= (sum_next <= 9'd255) ? sum_next[7:0] : 8'(9'd510 - sum_next);
            // black and gray pixels carry zero saturation and hue
            chroma1_reg <= (sum_next != 9'd0) && (mx_next != mn_next);
            hsel1_reg   <= hsel_next;
        end
    end

    // ---------------- stages 2..5: the four ratio dividers ----------------
    logic [QW-1:0] qr5, qg5, qb5, sat5;

    hslpa_recip_div u_div_r (.aclk(aclk), .en(en), .num(mx1_reg - r1_reg),
                             .den(d1_reg), .quot(qr5));
    hslpa_recip_div u_div_g (.aclk(aclk), .en(en), .num(mx1_reg - g1_reg),
                             .den(d1_reg), .quot(qg5));
    hslpa_recip_div u_div_b (.aclk(aclk), .en(en), .num(mx1_reg - b1_reg),
                             .den(d1_reg), .quot(qb5));
    hslpa_recip_div u_div_s (.aclk(aclk), .en(en), .num(d1_reg),
                             .den(den1_reg), .quot(sat5));

    // lightness by the constant 510, aligned with the dividers
    logic [QW-1:0] lq2_reg, lq3_reg, lum4_reg, lum5_reg;
    logic [16:0]   lt2_reg;
    logic [9:0]    lr3_reg;
    logic [33:0]   lq_full;
    logic [35:0]   lr_full;

    assign lq_full = 34'(sum1_reg) * 34'(hslpa_pkg::LUM_Q0);
    assign lr_full = 36'(lt2_reg) * 36'(hslpa_pkg::LUM_M);

    logic [7:0] alpha_dly_reg [4];
    logic [2:0] hsel_dly_reg  [4];
    logic       chroma_dly_reg[4];

    always_ff @(posedge aclk) begin
        if (en) begin
            lq2_reg  <= lq_full[QW-1:0];
            lt2_reg  <= 17'(17'(sum1_reg) * 17'(hslpa_pkg::LUM_R0) + 17'd509);
            lq3_reg  <= lq2_reg;
            lr3_reg  <= lr_full[hslpa_pkg::LUM_SH+9:hslpa_pkg::LUM_SH];
            lum4_reg <= lq3_reg + QW'(lr3_reg);
            lum5_reg <= lum4_reg;

            alpha_dly_reg[0]  <= alpha1_reg;
            hsel_dly_reg[0]   <= hsel1_reg;
            chroma_dly_reg[0] <= chroma1_reg;
            for (int k = 1; k < 4; k++) begin
                alpha_dly_reg[k]  <= alpha_dly_reg[k-1];
                hsel_dly_reg[k]   <= hsel_dly_reg[k-1];
                chroma_dly_reg[k] <= chroma_dly_reg[k-1];
            end
        end
    end

    // ---------------- stage 6: hue * 6 and gain scaling ----------------
    logic [H6W-1:0] h6_next;
    logic [QW-1:0]  sat_g;
    logic [40:0]    lp_full, sp_full;

    always_comb begin
        case (hsel_dly_reg[3])
            HUE_R_MAX_G_MIN: h6_next = 3'd5 * ONE_H + H6W'(qb5);
            HUE_R_MAX:       h6_next = ONE_H - H6W'(qg5);
            HUE_G_MAX_B_MIN: h6_next = ONE_H + H6W'(qr5);
            HUE_G_MAX:       h6_next = 3'd3 * ONE_H - H6W'(qb5);
            HUE_B_MAX_R_MIN: h6_next = 3'd3 * ONE_H + H6W'(qg5);
            default:         h6_next = 3'd5 * ONE_H - H6W'(qr5);
        endcase
        if (!chroma_dly_reg[3])
            h6_next = '0;
    end

    assign sat_g   = chroma_dly_reg[3] ? sat5 : '0;
    assign lp_full = 41'(lum5_reg) * 41'(lgain_reg);
    assign sp_full = 41'(sat_g) * 41'(sgain_reg);

    hslpa_pkg::hslpa_hsl_t hsl6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            hsl6_reg.alpha <= alpha_dly_reg[3];
            hsl6_reg.lp    <= lp_full[hslpa_pkg::GAIN_BITS+LPW-1:hslpa_pkg::GAIN_BITS];
            hsl6_reg.sp    <= sp_full[hslpa_pkg::GAIN_BITS+LPW-1:hslpa_pkg::GAIN_BITS];
            hsl6_reg.h6    <= h6_next;
        end
    end

    // ---------------- stages 7..11: back to RGB ----------------
    hslpa_rgb_rebuild u_rebuild (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[5]),
        .in_hsl    (hsl6_reg),
        .out_valid (m_tvalid),
        .out_pixel (m_tdata)
    );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench of the HSL saturation and lightness adjust pipeline.
`timescale 1ns / 100ps

module testbench;

    localparam int N_RANDOM = 2000;

    // an index that maps to no register
    localparam logic [hslpa_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 8'd7;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } argb_t;

    typedef struct {
        argb_t pix;
        bit    known;   // expected value typed in the table
        argb_t want;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [hslpa_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [hslpa_pkg::GAIN_W-1:0]    cfg_data = '0;

    // gains as the predictor sees them
    logic [hslpa_pkg::GAIN_W-1:0] lum_gain_q = hslpa_pkg::GAIN_RESET;
    logic [hslpa_pkg::GAIN_W-1:0] sat_gain_q = hslpa_pkg::GAIN_RESET;

    argb_t pending_pixels[$];
    int    error_count = 0;
    int    beats_checked = 0;
    bit    sink_steady = 1'b0;   // sink never stalls during this stretch
    bit    source_steady = 1'b0;

    hsl_lum_sat_pixel_adjust_unit dut (.*);

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end

    function automatic longint div_round_half_up(longint num, longint den);
        return (num + den / 2) / den;
    endfunction

    function automatic logic [7:0] channel_byte(longint c);
        longint t;
        if (c <= 0) return 8'd0;
        t = (c * 255 + 64) >>> hslpa_pkg::FRAC_BITS;
        return (t > 255) ? 8'd255 : t[7:0];
    endfunction

    // Bit-exact predicted pixel for the current gains
    function automatic argb_t adjust_pixel(argb_t p);
        longint one, r, g, b, mx, mn, sum, d, lum, sat, h6, den, qr, qg, qb;
        longint lp, sp, v, y, w, x, z, f, sext, cr, cg, cb;
        argb_t o;
        one = longint'(hslpa_pkg::ONE);
        r = p.red; g = p.green; b = p.blue;
        mx = (r > g) ? r : g; if (b > mx) mx = b;
        mn = (r < g) ? r : g; if (b < mn) mn = b;
        sum = mx + mn; d = mx - mn;
        lum = (sum * one + 509) / 510;
        sat = 0; h6 = 0;
        // black and gray leave saturation and hue at zero
        if (sum > 0 && d > 0) begin
            den = (sum <= 255) ? sum : 510 - sum;
            qr = div_round_half_up((mx - r) * one, d);
            qg = div_round_half_up((mx - g) * one, d);
            qb = div_round_half_up((mx - b) * one, d);
            sat = div_round_half_up(d * one, den);
            if (mx == r) h6 = (g == mn) ? 5 * one + qb : one - qg;
            else if (mx == g) h6 = (b == mn) ? one + qr : 3 * one - qb;
            else h6 = (r == mn) ? 3 * one + qg : 5 * one - qr;
        end
        lp = (lum * longint'(lum_gain_q)) >>> hslpa_pkg::GAIN_BITS;
        sp = (sat * longint'(sat_gain_q)) >>> hslpa_pkg::GAIN_BITS;
        if (lp <= one / 2) v = (lp * (one + sp)) >>> hslpa_pkg::FRAC_BITS;
        else v = lp + sp - ((lp * sp) >>> hslpa_pkg::FRAC_BITS);
        o.alpha = p.alpha;
        if (v <= 0) begin
            o.red = 0; o.green = 0; o.blue = 0;
            return o;
        end
        y = 2 * lp - v;
        sext = h6 >>> hslpa_pkg::FRAC_BITS;
        if (sext > 5) sext = 5;
        f = h6 - sext * one;
        w = ((v - y) * f) / one;
        x = y + w; z = v - w;
        case (sext)
            0: begin cr = v; cg = x; cb = y; end
            1: begin cr = z; cg = v; cb = y; end
            2: begin cr = y; cg = v; cb = x; end
            3: begin cr = y; cg = z; cb = v; end
            4: begin cr = x; cg = y; cb = v; end
            default: begin cr = v; cg = y; cb = z; end
        endcase
        o.red = channel_byte(cr); o.green = channel_byte(cg); o.blue = channel_byte(cb);
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        error_count++;
        $display("MISMATCH %s: got %0d, want %0d (beat %0d)", what, got, want, beats_checked);
    endtask

    // Sink: random stalls, check each beat against the oldest expected pixel
    always @(posedge aclk) begin
        argb_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_pixels.size() == 0) begin
                    report_mismatch("unexpected beat", int'(m_tdata), 0);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.alpha != want.alpha) report_mismatch("alpha", got.alpha, want.alpha);
                    if (got.red != want.red) report_mismatch("red", got.red, want.red);
                    if (got.green != want.green) report_mismatch("green", got.green, want.green);
                    if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
                end
                beats_checked++;
            end
            m_tready <= sink_steady ? 1'b1 : ($urandom_range(99) >= 26);
        end
    end

    // One register write; valid then drops and the predictor's gain is updated
    task automatic write_gain(logic [hslpa_pkg::CFG_IDX_W-1:0] idx,
                              logic [hslpa_pkg::GAIN_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == hslpa_pkg::REG_LIGHTNESS_GAIN) lum_gain_q = value;
        else if (idx == hslpa_pkg::REG_SATURATION_GAIN) sat_gain_q = value;
    endtask

    // Drop valid, hold until the pipe has drained, then let the latency pass
    task automatic wait_drained();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0 && guard < 100000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (16) @(posedge aclk);
    endtask

    // Send one beat; the expectation is queued when the beat is accepted
    task automatic send_pixel(argb_t p, argb_t want);
        while (!source_steady && $urandom_range(99) < 26) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        pending_pixels.push_back(want);
    endtask

    function automatic argb_t random_pixel();
        argb_t p;
        int shape;
        p = $urandom;
        shape = $urandom_range(9);
        // bias toward gray and black pixels, near-equal red and green, and full red
        if (shape == 0) begin p.green = p.red; p.blue = p.red; end
        else if (shape == 1) begin p.red = 0; p.green = 0; p.blue = 0; end
        else if (shape == 2) begin p.green = 8'(p.red + $urandom_range(2)); end
        else if (shape == 3) begin p.red = 8'hFF; end
        return p;
    endfunction

    initial begin
        stim_row_t rows[$];
        logic [hslpa_pkg::GAIN_W-1:0] gain_set[6][2];
        argb_t p;
        rows = '{
            '{32'h00000000, 1, 32'h00000000},   // black, alpha 0
            '{32'h000000FF, 1, 32'h000000FF},   // black, alpha 255
            '{32'hFFFFFF5A, 1, 32'hFFFFFF5A},   // white
            '{32'h0000FF11, 1, 32'h0000FF11},   // pure red
            '{32'h00FF0022, 1, 32'h00FF0022},   // pure green
            '{32'hFF000033, 1, 32'hFF000033},   // pure blue
            '{32'h80808044, 0, 32'h0},          // gray
            '{32'h0000FFFF, 0, 32'h0},          // red max, others min
            '{32'h00FFFF01, 0, 32'h0},          // yellow
            '{32'hFFFF0002, 0, 32'h0},          // cyan
            '{32'hFF00FF03, 0, 32'h0},          // magenta
            '{32'h10204080, 0, 32'h0},
            '{32'h40201080, 0, 32'h0},
            '{32'h20104080, 0, 32'h0},
            '{32'h40102080, 0, 32'h0},
            '{32'h10402080, 0, 32'h0},
            '{32'h20401080, 0, 32'h0},
            '{32'hAA5533C3, 0, 32'h0},
            '{32'h01010109, 0, 32'h0},
            '{32'hFEFEFF0A, 0, 32'h0}
        };
        gain_set = '{'{16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF}, '{16'h2000, 16'h0000},
                     '{16'h0800, 16'h3000}, '{16'h1000, 16'hFFFF}, '{16'h1333, 16'h0CCD}};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at reset gains
        foreach (rows[i])
            send_pixel(rows[i].pix, rows[i].known ? rows[i].want : adjust_pixel(rows[i].pix));
        wait_drained();

        // random phases over several gain settings, extremes first
        for (int ph = 0; ph < 7; ph++) begin
            if (ph < 6) begin
                write_gain(hslpa_pkg::REG_LIGHTNESS_GAIN, gain_set[ph][0]);
                write_gain(hslpa_pkg::REG_SATURATION_GAIN, gain_set[ph][1]);
            end else begin
                write_gain(hslpa_pkg::REG_LIGHTNESS_GAIN, 16'($urandom));
                write_gain(hslpa_pkg::REG_SATURATION_GAIN, 16'($urandom));
                write_gain(REG_UNMAPPED, 16'h0000);   // unknown index, ignored
            end
            for (int i = 0; i < N_RANDOM / 7; i++) begin
                // two stretches in one phase, split by a drain, with both sides streaming at full rate
                source_steady = (ph == 3 && i < 150);
                sink_steady = source_steady;
                p = random_pixel();
                send_pixel(p, adjust_pixel(p));
                if (i == 100) wait_drained();
            end
            wait_drained();
        end

        if (pending_pixels.size() != 0)
            report_mismatch("missing beats", 0, pending_pixels.size());

        $display("covered %0d pixels over seven gain settings, extremes included",
                 beats_checked);
        if (error_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
